@@ hw/rtl/vps_pkg.sv @@
// ----------------------------------------------------------------------------
// vps_pkg: shared types and helpers of the particle step block
// Payload structs, the queue entry, register indexes, the sequencer
// states and the fixed point helpers used by the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package vps_pkg;

  localparam int FRAC_BITS = 16;

  // Queue between the front and the back part.
  localparam int QDEPTH = 16;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Long division of a 62 bit product, one quotient bit per step.
  localparam int PROD_W   = 62;
  localparam int DIV_CNT_W = $clog2(PROD_W);
  localparam int ROOT_STEPS = 32;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY   = 2'd0,
    CFG_MAX_SPEED = 2'd1,
    CFG_BOX_WIDTH = 2'd2,
    CFG_BOX_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CL_IDLE,
    CL_SQUARE,
    CL_SUM,
    CL_ROOT,
    CL_DIVIDE,
    CL_DONE
  } clamp_state_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic [26:0]        radius;
    logic [16:0]        bounce;
    logic               pinned;
    logic [16:0]        time_step;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_prev_x;
    logic signed [31:0] new_prev_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } out_t;

  // One integrated particle on its way from the front to the back part.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic [32:0]        a;
    logic [32:0]        b;
    logic               over;
    logic [26:0]        radius;
    logic [16:0]        bounce;
  } entry_t;

  function automatic logic signed [35:0] ext36(input logic [31:0] v);
    return $signed({{4{v[31]}}, v});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return $signed(v[31:0]);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vps_front.sv @@
// ----------------------------------------------------------------------------
// vps_front: integration and classification pipeline
// Six stages that form the Verlet candidate, add gravity and decide
// whether the step has to be rescaled to the speed limit.
// ----------------------------------------------------------------------------
`default_nettype none

module vps_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire vps_pkg::in_t          item,
  input  wire logic signed [31:0]    gravity_accel,
  input  wire logic [30:0]           max_speed,
  output logic                       entry_valid,
  output vps_pkg::entry_t            entry
);
  import vps_pkg::*;

  localparam int DT2_W  = 34 - FRAC_BITS;
  localparam int GPROD_W = 32 + DT2_W + 1;
  localparam int ACC_W  = GPROD_W - FRAC_BITS;

  typedef struct packed {
    in_t                in;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic [32:0]        a;
    logic [32:0]        b;
    logic               big;
  } work_t;

  work_t w1, w2, w3, w4, w5, w6;
  logic  f1_v, f2_v, f3_v, f4_v, f5_v, f6_v;
  logic [DT2_W-1:0]         f1_dt2;
  logic signed [ACC_W-1:0]  f2_acc;
  logic [PROD_W-1:0]        sqa5, sqb5, mss5;
  logic                     over6;

  logic [33:0]               dt_sq;
  logic signed [35:0]        nx_wide;
  logic signed [GPROD_W-1:0] g_prod;
  logic signed [35:0]        ny_wide;
  logic signed [31:0]        ny_s;
  logic signed [32:0]        vx3, vy3;
  logic [32:0]               a4, b4;

  always_comb begin
    dt_sq   = 34'(item.time_step) * 34'(item.time_step);
    nx_wide = (ext36(item.pos_x) <<< 1) - ext36(item.prev_x);
    g_prod  = gravity_accel * $signed({1'b0, f1_dt2});
    ny_wide = (ext36(w2.in.pos_y) <<< 1) - ext36(w2.in.prev_y)
            + $signed({{(36 - ACC_W){f2_acc[ACC_W-1]}}, f2_acc});
    ny_s    = sat32(ny_wide);
    vx3     = $signed({w2.nx[31], w2.nx}) - $signed({w2.in.pos_x[31], w2.in.pos_x});
    vy3     = $signed({ny_s[31], ny_s}) - $signed({w2.in.pos_y[31], w2.in.pos_y});
    a4      = w3.vx[32] ? 33'(-w3.vx) : 33'(w3.vx);
    b4      = w3.vy[32] ? 33'(-w3.vy) : 33'(w3.vy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
      f4_v <= 1'b0;
      f5_v <= 1'b0;
      f6_v <= 1'b0;
    end else begin
      f1_v <= accept;
      f2_v <= f1_v;
      f3_v <= f2_v;
      f4_v <= f3_v;
      f5_v <= f4_v;
      f6_v <= f5_v;
    end
  end

  always_ff @(posedge clk) begin
    w1     <= '{in: item, nx: sat32(nx_wide), ny: '0, vx: '0, vy: '0,
                a: '0, b: '0, big: 1'b0};
    f1_dt2 <= dt_sq[33:FRAC_BITS];

    w2     <= w1;
    f2_acc <= g_prod[GPROD_W-1:FRAC_BITS];

    w3 <= '{in: w2.in, nx: w2.nx, ny: ny_s, vx: vx3, vy: vy3,
            a: w2.a, b: w2.b, big: w2.big};

    w4 <= '{in: w3.in, nx: w3.nx, ny: w3.ny, vx: w3.vx, vy: w3.vy, a: a4, b: b4,
            big: (a4 > {2'b00, max_speed}) || (b4 > {2'b00, max_speed})};

    // Below the limit on both axes the magnitudes fit in 31 bits.
    w5   <= w4;
    sqa5 <= w4.a[30:0] * w4.a[30:0];
    sqb5 <= w4.b[30:0] * w4.b[30:0];
    mss5 <= max_speed * max_speed;

    w6    <= w5;
    over6 <= w5.big || (({1'b0, sqa5} + {1'b0, sqb5}) > {1'b0, mss5});
  end

  always_comb begin
    entry_valid  = f6_v;
    entry.radius = w6.in.radius;
    entry.bounce = w6.in.bounce;
    entry.a      = w6.a;
    entry.b      = w6.b;
    if (w6.in.pinned) begin
      entry.px   = w6.in.pos_x;
      entry.py   = w6.in.pos_y;
      entry.ox   = w6.in.prev_x;
      entry.oy   = w6.in.prev_y;
      entry.vx   = '0;
      entry.vy   = '0;
      entry.over = 1'b0;
    end else begin
      entry.px   = w6.nx;
      entry.py   = w6.ny;
      entry.ox   = w6.in.pos_x;
      entry.oy   = w6.in.pos_y;
      entry.vx   = w6.vx;
      entry.vy   = w6.vy;
      entry.over = over6;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/vps_queue.sv @@
// ----------------------------------------------------------------------------
// vps_queue: short queue between the front and the back part
// Register based ring buffer; the head entry is shown combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module vps_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  input  wire vps_pkg::entry_t  wr_data,
  input  wire logic             rd_ready,
  output logic                  rd_valid,
  output vps_pkg::entry_t       rd_data
);
  import vps_pkg::*;

  entry_t              slots [QDEPTH];
  logic [QPTR_W-1:0]   wptr, rptr;
  logic [QCNT_W-1:0]   count;
  logic                do_rd;

  assign rd_valid = (count != '0);
  assign rd_data  = slots[rptr];
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_valid) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr_valid && !do_rd) begin
        count <= count + 1'b1;
      end else if (!wr_valid && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/vps_back.sv @@
// ----------------------------------------------------------------------------
// vps_back: speed clamp sequencer and wall constraint pipeline
// A sequencer rescales steps over the speed limit with a square root
// and two long divisions; three stages then apply the box walls.
// ----------------------------------------------------------------------------
`default_nettype none

module vps_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire vps_pkg::entry_t  q_head,
  output logic                  q_pop,
  input  wire logic [30:0]      max_speed,
  input  wire logic [14:0]      box_width,
  input  wire logic [14:0]      box_height,
  input  wire logic             pop,
  output logic                  empty,
  output vps_pkg::out_t         result
);
  import vps_pkg::*;

  localparam int WPROD_W = 33 + 18;
  localparam int WSH_W   = WPROD_W - FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] pn;
    logic signed [32:0] d;
    logic               hit;
  } wall_t;

  function automatic wall_t wall_fn(input logic signed [31:0] p, input logic [26:0] r,
                                    input logic signed [31:0] o, input logic [30:0] lim);
    wall_t              w;
    logic signed [35:0] lo_t;
    logic signed [35:0] hi_t;
    logic               lo;
    logic               hi;
    lo_t  = ext36(p) - $signed({9'b0, r});
    hi_t  = ext36(p) + $signed({9'b0, r});
    lo    = lo_t[35];
    hi    = hi_t > $signed({5'b0, lim});
    w.d   = $signed({p[31], p}) - $signed({o[31], o});
    w.hit = lo || hi;
    if (lo) begin
      w.pn = $signed({5'b0, r});
    end else if (hi) begin
      w.pn = $signed({1'b0, lim}) - $signed({5'b0, r});
    end else begin
      w.pn = p;
    end
    return w;
  endfunction

  // Clamp sequencer state.
  clamp_state_t          st, st_next;
  entry_t                b0;
  logic                  b0_v, b0_done, b0_move, adv;
  logic [30:0]           ea, eb;
  logic [PROD_W-1:0]     sqa, sqb, dvx, dvy, qx, qy;
  logic [63:0]           n, res;
  logic [ROOT_CNT_W-1:0] k;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [31:0]           remx, remy, len;

  logic [63:0] root_bit, root_cand;
  logic [32:0] shx, shy;
  logic        ea_shift;

  // Wall pipeline.
  entry_t  fin, b1;
  logic    b1_v, b2_v, b3_v, out_v;
  wall_t   wx, wy, wx2, wy2;
  logic signed [31:0] b2_ox, b2_oy, b3_ox, b3_oy, b3_px, b3_py;
  logic signed [32:0] b2_vx, b2_vy, b3_vx, b3_vy;
  logic [16:0]        b2_bounce;
  logic               b3_hx, b3_hy;
  logic signed [WPROD_W-1:0] prx, pry;
  logic signed [WSH_W-1:0]   b3_sx, b3_sy;
  logic signed [35:0]        sumx, sumy;

  logic [30:0]        cx, cy;
  logic signed [32:0] vxc, vyc;

  assign adv     = !out_v || pop;
  assign b0_move = b0_v && b0_done && adv;
  assign q_pop   = q_valid && (!b0_v || b0_move);
  assign empty   = !out_v;

  always_comb begin
    st_next = st;
    unique case (st)
      CL_IDLE:   if (b0_v && b0.over) st_next = CL_SQUARE;
      CL_SQUARE: st_next = CL_SUM;
      CL_SUM:    st_next = CL_ROOT;
      CL_ROOT:   if (k == '0) st_next = CL_DIVIDE;
      CL_DIVIDE: if (cnt == '0) st_next = CL_DONE;
      CL_DONE:   if (b0_move) st_next = CL_IDLE;
      default:   st_next = CL_IDLE;
    endcase
  end

  always_comb begin
    b0_done = !b0.over || (st == CL_DONE);
  end

  always_comb begin
    ea_shift  = b0.a[32] || b0.a[31] || b0.b[32] || b0.b[31];
    root_bit  = 64'd1 << {k, 1'b0};
    root_cand = res + root_bit;
    len       = (res[31:0] == '0) ? 32'd1 : res[31:0];
    shx       = {remx, dvx[PROD_W-1]};
    shy       = {remy, dvy[PROD_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= CL_IDLE;
      b0_v <= 1'b0;
    end else begin
      st <= st_next;
      if (q_pop) begin
        b0_v <= 1'b1;
      end else if (b0_move) begin
        b0_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b0 <= q_head;
    end
    unique case (st)
      CL_IDLE: begin
        // Bring both magnitudes below 2^31 before squaring.
        ea <= ea_shift ? b0.a[31:1] : b0.a[30:0];
        eb <= ea_shift ? b0.b[31:1] : b0.b[30:0];
      end
      CL_SQUARE: begin
        sqa <= ea * ea;
        sqb <= eb * eb;
        dvx <= ea * max_speed;
        dvy <= eb * max_speed;
      end
      CL_SUM: begin
        n   <= {2'b00, sqa} + {2'b00, sqb};
        res <= '0;
        k   <= ROOT_CNT_W'(ROOT_STEPS - 1);
      end
      CL_ROOT: begin
        if (n >= root_cand) begin
          n   <= n - root_cand;
          res <= (res >> 1) + root_bit;
        end else begin
          res <= res >> 1;
        end
        k    <= k - 1'b1;
        remx <= '0;
        remy <= '0;
        cnt  <= DIV_CNT_W'(PROD_W - 1);
      end
      CL_DIVIDE: begin
        if (shx >= {1'b0, len}) begin
          remx <= 32'(shx - {1'b0, len});
          qx   <= {qx[PROD_W-2:0], 1'b1};
        end else begin
          remx <= shx[31:0];
          qx   <= {qx[PROD_W-2:0], 1'b0};
        end
        if (shy >= {1'b0, len}) begin
          remy <= 32'(shy - {1'b0, len});
          qy   <= {qy[PROD_W-2:0], 1'b1};
        end else begin
          remy <= shy[31:0];
          qy   <= {qy[PROD_W-2:0], 1'b0};
        end
        dvx <= dvx << 1;
        dvy <= dvy << 1;
        cnt <= cnt - 1'b1;
      end
      CL_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Rescaled step, applied from the position before integration.
  always_comb begin
    cx  = (qx > {31'b0, max_speed}) ? max_speed : qx[30:0];
    cy  = (qy > {31'b0, max_speed}) ? max_speed : qy[30:0];
    vxc = b0.vx[32] ? -$signed({2'b00, cx}) : $signed({2'b00, cx});
    vyc = b0.vy[32] ? -$signed({2'b00, cy}) : $signed({2'b00, cy});
    fin = b0;
    if (b0.over) begin
      fin.vx = vxc;
      fin.vy = vyc;
      fin.px = sat32(ext36(b0.ox) + $signed({{3{vxc[32]}}, vxc}));
      fin.py = sat32(ext36(b0.oy) + $signed({{3{vyc[32]}}, vyc}));
    end
  end

  always_comb begin
    wx   = wall_fn(b1.px, b1.radius, b1.ox, {box_width, {FRAC_BITS{1'b0}}});
    wy   = wall_fn(b1.py, b1.radius, b1.oy, {box_height, {FRAC_BITS{1'b0}}});
    prx  = wx2.d * $signed({1'b0, b2_bounce});
    pry  = wy2.d * $signed({1'b0, b2_bounce});
    sumx = ext36(b3_px) + $signed({{(36 - WSH_W){b3_sx[WSH_W-1]}}, b3_sx});
    sumy = ext36(b3_py) + $signed({{(36 - WSH_W){b3_sy[WSH_W-1]}}, b3_sy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v  <= 1'b0;
      b2_v  <= 1'b0;
      b3_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (adv) begin
      b1_v  <= b0_v && b0_done;
      b2_v  <= b1_v;
      b3_v  <= b2_v;
      out_v <= b3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1 <= fin;

      wx2       <= wx;
      wy2       <= wy;
      b2_ox     <= b1.ox;
      b2_oy     <= b1.oy;
      b2_vx     <= b1.vx;
      b2_vy     <= b1.vy;
      b2_bounce <= b1.bounce;

      b3_px <= wx2.pn;
      b3_py <= wy2.pn;
      b3_hx <= wx2.hit;
      b3_hy <= wy2.hit;
      b3_sx <= prx[WPROD_W-1:FRAC_BITS];
      b3_sy <= pry[WPROD_W-1:FRAC_BITS];
      b3_ox <= b2_ox;
      b3_oy <= b2_oy;
      b3_vx <= b2_vx;
      b3_vy <= b2_vy;

      result.new_x      <= b3_px;
      result.new_y      <= b3_py;
      result.new_prev_x <= b3_hx ? sat32(sumx) : b3_ox;
      result.new_prev_y <= b3_hy ? sat32(sumy) : b3_oy;
      result.vel_x      <= b3_vx[31:0];
      result.vel_y      <= b3_vy[31:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/verlet_particle_step.sv @@
// ----------------------------------------------------------------------------
// verlet_particle_step: one Verlet step with speed limit and box walls
// Integrates one particle per request in signed Q16.16 and keeps it inside
// the screen box.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests are pushed with push while full is low. Results come out
//   in order; the oldest one is on result while empty is low and leaves on
//   pop. Registers are written through cfg_valid/cfg_ready with cfg_index and
//   cfg_data, always ready; the user must write them only while no request
//   is in flight, since the block does not enforce this.
//   Throughput: one particle per cycle while no step has to be rescaled and
//   the receiver keeps popping. A step over the speed limit holds the back
//   sequencer through square, sum, a 32 step square root and a 62 step long
//   division; the front keeps accepting until 16 requests are in flight.
//   Reset brings the registers to their defaults and empties every stage.
//   When the receiver stalls, the wall stages hold and the queue fills;
//   full rises once 16 requests are waiting in the front and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module verlet_particle_step (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire vps_pkg::in_t                   item,
  output logic                                empty,
  input  wire logic                           pop,
  output vps_pkg::out_t                       result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [vps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import vps_pkg::*;

  logic signed [31:0] gravity_accel;
  logic [30:0]        max_speed;
  logic [14:0]        box_width, box_height;
  logic [QCNT_W-1:0]  inflight;
  logic               accept, e_valid, q_valid, q_pop;
  entry_t             e_data, q_head;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign full      = (inflight == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_accel <= 32'sd65536000;
      max_speed     <= 31'd655360;
      box_width     <= 15'd800;
      box_height    <= 15'd600;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRAVITY:    gravity_accel <= $signed(cfg_data);
        CFG_MAX_SPEED:  max_speed     <= cfg_data[30:0];
        CFG_BOX_WIDTH:  box_width     <= cfg_data[14:0];
        CFG_BOX_HEIGHT: box_height    <= cfg_data[14:0];
      endcase
    end
  end

  // Requests in the front stages or the queue each hold a queue slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (accept && !q_pop) begin
      inflight <= inflight + 1'b1;
    end else if (!accept && q_pop) begin
      inflight <= inflight - 1'b1;
    end
  end

  vps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (item),
    .gravity_accel (gravity_accel),
    .max_speed     (max_speed),
    .entry_valid   (e_valid),
    .entry         (e_data)
  );

  vps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (e_valid),
    .wr_data  (e_data),
    .rd_ready (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_head)
  );

  vps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .max_speed  (max_speed),
    .box_width  (box_width),
    .box_height (box_height),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= QCNT_W'(QDEPTH))
    else $error("in-flight count exceeds the queue depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue read while empty");

  a_idle_queue: assert property (@(posedge clk) disable iff (rst)
    (inflight == '0) |-> !q_valid)
    else $error("queue holds an entry with nothing in flight");

endmodule

`default_nettype wire

@@ verif/verlet_particle_step_tb.sv @@
// ----------------------------------------------------------------------------
// verlet_particle_step_tb: self-checking bench for the particle step block
// Streams directed and random particles through the block under several
// register settings. Each accepted request is predicted in fixed point and
// every popped result is compared field by field, with random idling on
// both sides, a long receiver stall and drain pauses between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module verlet_particle_step_tb;
  import vps_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  in_t        item = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_t       result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  verlet_particle_step u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers.
  longint          grav_acc;
  longint unsigned speed_lim;
  longint          box_w, box_h;

  in_t  pending_particles[$];
  out_t expected_steps[$];
  int   mismatches = 0;
  bit   quiet = 1'b0;
  bit   long_stall_req = 1'b0;
  bit   long_stall_done = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   stall_cnt = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void wall_fit(inout longint p, inout longint old, input longint d,
                                   input longint r, input longint lim, input longint rest);
    bit hit;
    hit = 1'b0;
    if (p - r < 0) begin
      p = r;
      hit = 1'b1;
    end else if (p + r > lim) begin
      p = sat_q(lim - r);
      hit = 1'b1;
    end
    if (hit) old = sat_q(p + ((d * rest) >>> FRAC_BITS));
  endfunction

  function automatic out_t predict_step(in_t it);
    longint px, py, ox, oy, r, rest, dt, dt2, acc, nx, ny, vx, vy, dx, dy;
    longint unsigned a, b, ms, len, cx, cy;
    bit over;
    out_t o;
    px = it.pos_x;
    py = it.pos_y;
    ox = it.prev_x;
    oy = it.prev_y;
    r = longint'(it.radius);
    rest = longint'(it.bounce);
    dt = longint'(it.time_step);
    vx = 0;
    vy = 0;
    if (!it.pinned) begin
      dt2 = (dt * dt) >>> FRAC_BITS;
      acc = (grav_acc * dt2) >>> FRAC_BITS;
      nx = sat_q(2 * px - ox);
      ny = sat_q(2 * py - oy + acc);
      vx = nx - px;
      vy = ny - py;
      a = (vx < 0) ? longint'(-vx) : longint'(vx);
      b = (vy < 0) ? longint'(-vy) : longint'(vy);
      ms = speed_lim;
      if (a > ms || b > ms) over = 1'b1;
      else over = (a * a + b * b) > (ms * ms);
      if (over) begin
        while (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
          a = a >> 1;
          b = b >> 1;
        end
        len = int_sqrt(a * a + b * b);
        if (len == 0) len = 1;
        cx = a * ms / len;
        cy = b * ms / len;
        if (cx > ms) cx = ms;
        if (cy > ms) cy = ms;
        vx = (vx < 0) ? -longint'(cx) : longint'(cx);
        vy = (vy < 0) ? -longint'(cy) : longint'(cy);
        nx = sat_q(px + vx);
        ny = sat_q(py + vy);
      end
      ox = px;
      oy = py;
      px = nx;
      py = ny;
    end
    dx = px - ox;
    dy = py - oy;
    wall_fit(px, ox, dx, r, box_w << FRAC_BITS, rest);
    wall_fit(py, oy, dy, r, box_h << FRAC_BITS, rest);
    o.new_x = px[31:0];
    o.new_y = py[31:0];
    o.new_prev_x = ox[31:0];
    o.new_prev_y = oy[31:0];
    o.vel_x = vx[31:0];
    o.vel_y = vy[31:0];
    return o;
  endfunction

  // Driver: offers pending particles, holds a request until accepted.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && full) begin
      // Request stays on the port until the block takes it.
    end else begin
      if (push) expected_steps.push_back(predict_step(item));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        push <= 1'b0;
      end else if (pending_particles.size() > 0) begin
        push <= 1'b1;
        item <= pending_particles.pop_front();
        if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 16);
      end else begin
        push <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h actual %h", name, exp_v, act_v);
    end
  endtask

  // Monitor: pops results and compares them against the oldest prediction.
  always @(posedge clk) begin
    out_t e;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_steps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: result with no request pending");
        end else begin
          e = expected_steps.pop_front();
          check_field("new_x", e.new_x, result.new_x);
          check_field("new_y", e.new_y, result.new_y);
          check_field("new_prev_x", e.new_prev_x, result.new_prev_x);
          check_field("new_prev_y", e.new_prev_y, result.new_prev_y);
          check_field("vel_x", e.vel_x, result.vel_x);
          check_field("vel_y", e.vel_y, result.vel_y);
        end
      end
      if (long_stall_req && !long_stall_done) begin
        long_stall_done <= 1'b1;
        stall_cnt <= 600;
        pop <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 16);
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GRAVITY:    grav_acc = longint'($signed(val));
      CFG_MAX_SPEED:  speed_lim = longint'(val[30:0]);
      CFG_BOX_WIDTH:  box_w = longint'(val[14:0]);
      CFG_BOX_HEIGHT: box_h = longint'(val[14:0]);
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] g, logic [31:0] ms, logic [31:0] w, logic [31:0] h);
    write_reg(CFG_GRAVITY, g);
    write_reg(CFG_MAX_SPEED, ms);
    write_reg(CFG_BOX_WIDTH, w);
    write_reg(CFG_BOX_HEIGHT, h);
  endtask

  task automatic drain;
    while (pending_particles.size() != 0 || push || expected_steps.size() != 0)
      @(posedge clk);
    // No request is left in the block here; the wait adds a pause between phases.
    repeat (150) @(posedge clk);
  endtask

  function automatic in_t make_particle(int mode);
    in_t p;
    int span;
    p.pos_x = $urandom;
    p.pos_y = $urandom;
    p.prev_x = $urandom;
    p.prev_y = $urandom;
    p.radius = $urandom_range(0, 27'h400_0000);
    p.bounce = $urandom_range(0, 65536);
    p.pinned = ($urandom_range(0, 9) == 0);
    p.time_step = $urandom_range(0, 65536);
    if (mode != 0) begin
      // Realistic particle inside or near the box with a modest step.
      span = (mode == 1) ? (2 << FRAC_BITS) : (30 << FRAC_BITS);
      p.pos_x = $urandom_range(0, (box_w + 20) << FRAC_BITS) - (10 << FRAC_BITS);
      p.pos_y = $urandom_range(0, (box_h + 20) << FRAC_BITS) - (10 << FRAC_BITS);
      p.prev_x = p.pos_x + $signed($urandom_range(0, 2 * span)) - span;
      p.prev_y = p.pos_y + $signed($urandom_range(0, 2 * span)) - span;
      p.radius = $urandom_range(0, 20 << FRAC_BITS);
      if ($urandom_range(0, 1)) p.time_step = $urandom_range(0, 4000);
    end
    return p;
  endfunction

  task automatic queue_random(int n);
    int k;
    for (k = 0; k < n; k++)
      pending_particles.push_back(make_particle($urandom_range(0, 7) == 0 ? 0 :
                                                $urandom_range(1, 2)));
  endtask

  task automatic queue_directed;
    in_t p;
    p = '0;
    pending_particles.push_back(p);
    p.pinned = 1'b1;
    p.pos_x = 32'sh7fffffff; p.pos_y = 32'sh80000000;
    pending_particles.push_back(p);
    p = '1;
    pending_particles.push_back(p);
    p = '0;
    p.pos_x = 32'sh7fffffff; p.prev_x = 32'sh80000000;
    p.pos_y = 32'sh80000000; p.prev_y = 32'sh7fffffff;
    p.time_step = 17'd65536; p.bounce = 17'd65536; p.radius = 27'h400_0000;
    pending_particles.push_back(p);
    p.pinned = 1'b1;
    pending_particles.push_back(p);
    p = '0;
    p.pos_x = 100 << FRAC_BITS; p.pos_y = 100 << FRAC_BITS;
    p.prev_x = 50 << FRAC_BITS; p.prev_y = 160 << FRAC_BITS;
    p.radius = 5 << FRAC_BITS; p.bounce = 17'd32768; p.time_step = 17'd1092;
    pending_particles.push_back(p);
    p.prev_x = p.pos_x - (3 << FRAC_BITS); p.prev_y = p.pos_y;
    pending_particles.push_back(p);
    // Particles moving through each of the four walls.
    p.pos_x = 1 << FRAC_BITS; p.prev_x = 4 << FRAC_BITS;
    pending_particles.push_back(p);
    p.pos_x = (box_w - 1) << FRAC_BITS; p.prev_x = (box_w - 4) << FRAC_BITS;
    pending_particles.push_back(p);
    p.pos_x = 200 << FRAC_BITS; p.prev_x = p.pos_x;
    p.pos_y = 1 << FRAC_BITS; p.prev_y = 4 << FRAC_BITS;
    pending_particles.push_back(p);
    p.pos_y = (box_h - 1) << FRAC_BITS; p.prev_y = (box_h - 4) << FRAC_BITS;
    pending_particles.push_back(p);
    p.time_step = 17'd0;
    pending_particles.push_back(p);
    p.time_step = 17'd65536; p.bounce = 17'd65536;
    pending_particles.push_back(p);
    p.radius = 27'h400_0000; p.bounce = 17'd0;
    pending_particles.push_back(p);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    grav_acc = 65536000;
    speed_lim = 655360;
    box_w = 800;
    box_h = 600;

    set_regs(32'd65536000, 32'd655360, 32'd800, 32'd600);
    queue_directed();
    queue_random(400);
    drain();

    set_regs(32'h8000_0000, 32'd0, 32'd1, 32'd1);
    queue_directed();
    queue_random(300);
    drain();

    set_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'd32767, 32'd32767);
    long_stall_req <= 1'b1;
    queue_directed();
    queue_random(400);
    drain();

    set_regs($urandom, $urandom, $urandom_range(1, 32767), $urandom_range(1, 32767));
    queue_random(400);
    drain();

    set_regs($urandom_range(0, 200_000_000), $urandom_range(65536, 2_000_000),
             $urandom_range(100, 2000), $urandom_range(100, 2000));
    queue_random(300);
    drain();

    quiet = 1'b1;
    set_regs(32'd65536000, 32'd655360, 32'd800, 32'd600);
    queue_random(200);
    drain();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/vps_pkg.sv
hw/rtl/vps_front.sv
hw/rtl/vps_queue.sv
hw/rtl/vps_back.sv
hw/rtl/verlet_particle_step.sv
verif/verlet_particle_step_tb.sv
